FILE: hdl/bir_pkg.sv
// Package for the bilinear image resize block: widths, register indexes,
// command codes, request and response payload types, and the blend function.
// No dependencies.
package bir_pkg;

   // Frame store geometry and fixed-point format.
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int FRAC_BITS      = 16;
   localparam int COL_BITS       = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_SRC_HEIGHT);

   // The store is split into four banks by row parity and column parity.
   localparam int NUM_BANKS      = 4;
   localparam int BANK_ADDR_BITS = (COL_BITS - 1) + (ROW_BITS - 1);
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;

   // Field and register widths.
   localparam int SIZE_BITS   = 9;
   localparam int STEP_BITS   = 24;
   localparam int COORD_BITS  = 12;
   localparam int PIXEL_BITS  = 8;
   localparam int POS_BITS    = COORD_BITS + STEP_BITS;
   localparam int INT_BITS    = POS_BITS - FRAC_BITS;
   localparam int BLEND_BITS  = PIXEL_BITS + FRAC_BITS + 2;

   // Register reset values.
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(256);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1 << FRAC_BITS);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SOURCE_WIDTH    = 2'd0,
      CSR_SOURCE_HEIGHT   = 2'd1,
      CSR_HORIZONTAL_STEP = 2'd2,
      CSR_VERTICAL_STEP   = 2'd3
   } csr_index_type;

   // Request commands.
   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [7:0]             load_col;
      logic [7:0]             load_row;
      logic [PIXEL_BITS-1:0]  load_pixel;
      logic [COORD_BITS-1:0]  query_col;
      logic [COORD_BITS-1:0]  query_row;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]  result_pixel;
      logic [COORD_BITS-1:0]  result_col;
      logic [COORD_BITS-1:0]  result_row;
   } rsp_type;

   // Linear blend of two pixels by a fraction, truncated: floor((a*(1-f) + b*f)).
   // The result always fits in a pixel, so no saturation is needed.
   function automatic logic [PIXEL_BITS-1:0] blend(input logic [PIXEL_BITS-1:0] a,
                                                    input logic [PIXEL_BITS-1:0] b,
                                                    input logic [FRAC_BITS-1:0]  f);
      logic [FRAC_BITS:0]    inv;
      logic [BLEND_BITS-1:0] acc;
      inv = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f};
      acc = BLEND_BITS'(a) * BLEND_BITS'(inv) + BLEND_BITS'(b) * BLEND_BITS'(f);
      return acc[FRAC_BITS +: PIXEL_BITS];
   endfunction

endpackage

FILE: hdl/bilinear_image_resize_top.sv
// A query request passes through the position stage, the memory read, the horizontal pass and the output register.
// Throughput: one request (load or query) per cycle; the whole pipeline holds while
// a finished response waits in the output register and is not taken.
// Reset clears the valid bits and restores the configuration registers; the frame store,
// banked by row and column parity for four reads a cycle, is not cleared.
// Depends on bir_pkg.
module bilinear_image_resize_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bir_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bir_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  bir_pkg::csr_index_type            csr_index,
   input  logic [bir_pkg::STEP_BITS-1:0]     csr_wdata
);

   // Configuration registers.
   logic [bir_pkg::SIZE_BITS-1:0] source_width_ff;
   logic [bir_pkg::SIZE_BITS-1:0] source_height_ff;
   logic [bir_pkg::STEP_BITS-1:0] horizontal_step_ff;
   logic [bir_pkg::STEP_BITS-1:0] vertical_step_ff;

   // Last usable column and row after size clamping.
   logic [bir_pkg::COL_BITS-1:0] width_last;
   logic [bir_pkg::ROW_BITS-1:0] height_last;

   // Pipeline enable: every stage moves when the output register is free or drained.
   logic advance;

   // Position stage.
   logic                              p_valid_ff;
   bir_pkg::cmd_type                  p_cmd_ff;
   logic [7:0]                        p_load_col_ff;
   logic [7:0]                        p_load_row_ff;
   logic [bir_pkg::PIXEL_BITS-1:0]    p_load_pixel_ff;
   logic [bir_pkg::COORD_BITS-1:0]    p_qcol_ff;
   logic [bir_pkg::COORD_BITS-1:0]    p_qrow_ff;
   logic [bir_pkg::POS_BITS-1:0]      p_px_ff;
   logic [bir_pkg::POS_BITS-1:0]      p_py_ff;
   logic [bir_pkg::POS_BITS-1:0]      p_px_in;
   logic [bir_pkg::POS_BITS-1:0]      p_py_in;

   // Address generation for the memory read.
   logic [bir_pkg::INT_BITS-1:0]  pos_x;
   logic [bir_pkg::INT_BITS-1:0]  pos_y;
   logic                          clamp_x;
   logic                          clamp_y;
   logic [bir_pkg::COL_BITS-1:0]  col0;
   logic [bir_pkg::COL_BITS-1:0]  col1;
   logic [bir_pkg::ROW_BITS-1:0]  row0;
   logic [bir_pkg::ROW_BITS-1:0]  row1;
   logic [bir_pkg::COL_BITS-2:0]  col_even_idx;
   logic [bir_pkg::COL_BITS-2:0]  col_odd_idx;
   logic [bir_pkg::ROW_BITS-2:0]  row_even_idx;
   logic [bir_pkg::ROW_BITS-2:0]  row_odd_idx;
   logic                              wr_en;
   logic [1:0]                        wr_bank;
   logic [bir_pkg::BANK_ADDR_BITS-1:0] wr_addr;
   logic [bir_pkg::BANK_ADDR_BITS-1:0] rd_addr [bir_pkg::NUM_BANKS];
   logic [bir_pkg::PIXEL_BITS-1:0]     bank_q_ff [bir_pkg::NUM_BANKS];

   // Memory stage sideband.
   logic                              m_valid_ff;
   logic [bir_pkg::COORD_BITS-1:0]    m_qcol_ff;
   logic [bir_pkg::COORD_BITS-1:0]    m_qrow_ff;
   logic [bir_pkg::FRAC_BITS-1:0]     m_fx_ff;
   logic [bir_pkg::FRAC_BITS-1:0]     m_fy_ff;
   logic                              m_col0_par_ff;
   logic                              m_col1_par_ff;
   logic                              m_row0_par_ff;
   logic                              m_row1_par_ff;

   // Horizontal pass stage.
   logic                              h_valid_ff;
   logic [bir_pkg::COORD_BITS-1:0]    h_qcol_ff;
   logic [bir_pkg::COORD_BITS-1:0]    h_qrow_ff;
   logic [bir_pkg::FRAC_BITS-1:0]     h_fy_ff;
   logic [bir_pkg::PIXEL_BITS-1:0]    h_top_ff;
   logic [bir_pkg::PIXEL_BITS-1:0]    h_bot_ff;
   logic [bir_pkg::PIXEL_BITS-1:0]    h_top_in;
   logic [bir_pkg::PIXEL_BITS-1:0]    h_bot_in;

   // Output register.
   logic                              rsp_valid_ff;
   bir_pkg::rsp_type                  rsp_data_ff;
   bir_pkg::rsp_type                  rsp_data_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff    <= bir_pkg::SIZE_RESET;
         source_height_ff   <= bir_pkg::SIZE_RESET;
         horizontal_step_ff <= bir_pkg::STEP_RESET;
         vertical_step_ff   <= bir_pkg::STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bir_pkg::CSR_SOURCE_WIDTH:    source_width_ff    <= csr_wdata[bir_pkg::SIZE_BITS-1:0];
            bir_pkg::CSR_SOURCE_HEIGHT:   source_height_ff   <= csr_wdata[bir_pkg::SIZE_BITS-1:0];
            bir_pkg::CSR_HORIZONTAL_STEP: horizontal_step_ff <= csr_wdata;
            bir_pkg::CSR_VERTICAL_STEP:   vertical_step_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the sizes: zero acts as one, anything above the store saturates.
   always_comb begin
      if (source_width_ff == '0) begin
         width_last = '0;
      end else if (source_width_ff > bir_pkg::SIZE_BITS'(bir_pkg::MAX_SRC_WIDTH)) begin
         width_last = bir_pkg::COL_BITS'(bir_pkg::MAX_SRC_WIDTH - 1);
      end else begin
         width_last = bir_pkg::COL_BITS'(source_width_ff - 1'b1);
      end
      if (source_height_ff == '0) begin
         height_last = '0;
      end else if (source_height_ff > bir_pkg::SIZE_BITS'(bir_pkg::MAX_SRC_HEIGHT)) begin
         height_last = bir_pkg::ROW_BITS'(bir_pkg::MAX_SRC_HEIGHT - 1);
      end else begin
         height_last = bir_pkg::ROW_BITS'(source_height_ff - 1'b1);
      end
   end

   // Source position: output coordinate times the fixed-point step.
   assign p_px_in = bir_pkg::POS_BITS'(req_data.query_col)
                  * bir_pkg::POS_BITS'(horizontal_step_ff);
   assign p_py_in = bir_pkg::POS_BITS'(req_data.query_row)
                  * bir_pkg::POS_BITS'(vertical_step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_cmd_ff        <= req_data.cmd;
         p_load_col_ff   <= req_data.load_col;
         p_load_row_ff   <= req_data.load_row;
         p_load_pixel_ff <= req_data.load_pixel;
         p_qcol_ff       <= req_data.query_col;
         p_qrow_ff       <= req_data.query_row;
         p_px_ff         <= p_px_in;
         p_py_ff         <= p_py_in;
      end
   end

   // Neighbor coordinates. At or past the edge both neighbors are the edge pixel,
   // which makes the blend return that pixel unchanged.
   always_comb begin
      pos_x   = p_px_ff[bir_pkg::POS_BITS-1:bir_pkg::FRAC_BITS];
      pos_y   = p_py_ff[bir_pkg::POS_BITS-1:bir_pkg::FRAC_BITS];
      clamp_x = pos_x >= bir_pkg::INT_BITS'(width_last);
      clamp_y = pos_y >= bir_pkg::INT_BITS'(height_last);
      col0    = clamp_x ? width_last : pos_x[bir_pkg::COL_BITS-1:0];
      col1    = clamp_x ? width_last : pos_x[bir_pkg::COL_BITS-1:0] + 1'b1;
      row0    = clamp_y ? height_last : pos_y[bir_pkg::ROW_BITS-1:0];
      row1    = clamp_y ? height_last : pos_y[bir_pkg::ROW_BITS-1:0] + 1'b1;
      // Each neighbor pair has one even and one odd member, unless both are the edge.
      col_even_idx = col0[0] ? col1[bir_pkg::COL_BITS-1:1] : col0[bir_pkg::COL_BITS-1:1];
      col_odd_idx  = col0[0] ? col0[bir_pkg::COL_BITS-1:1] : col1[bir_pkg::COL_BITS-1:1];
      row_even_idx = row0[0] ? row1[bir_pkg::ROW_BITS-1:1] : row0[bir_pkg::ROW_BITS-1:1];
      row_odd_idx  = row0[0] ? row0[bir_pkg::ROW_BITS-1:1] : row1[bir_pkg::ROW_BITS-1:1];
   end

   // Loads write the store in the same stage where queries read it, so order holds.
   assign wr_en   = advance && p_valid_ff && (p_cmd_ff == bir_pkg::CMD_LOAD);
   assign wr_bank = {p_load_row_ff[0], p_load_col_ff[0]};
   assign wr_addr = {p_load_row_ff[bir_pkg::ROW_BITS-1:1], p_load_col_ff[bir_pkg::COL_BITS-1:1]};

   // Four frame store banks, selected by row parity (upper bit) and column parity.
   for (genvar b = 0; b < bir_pkg::NUM_BANKS; b++) begin : g_bank
      localparam logic [1:0] BANK = 2'(b);
      logic [bir_pkg::PIXEL_BITS-1:0] bank_mem [bir_pkg::BANK_DEPTH];

      assign rd_addr[b] = {(BANK[1] ? row_odd_idx : row_even_idx),
                           (BANK[0] ? col_odd_idx : col_even_idx)};

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == BANK)) begin
            bank_mem[wr_addr] <= p_load_pixel_ff;
         end
         if (advance) begin
            bank_q_ff[b] <= bank_mem[rd_addr[b]];
         end
      end
   end

   // Memory stage: only queries continue past the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= p_valid_ff && (p_cmd_ff == bir_pkg::CMD_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_qcol_ff     <= p_qcol_ff;
         m_qrow_ff     <= p_qrow_ff;
         m_fx_ff       <= p_px_ff[bir_pkg::FRAC_BITS-1:0];
         m_fy_ff       <= p_py_ff[bir_pkg::FRAC_BITS-1:0];
         m_col0_par_ff <= col0[0];
         m_col1_par_ff <= col1[0];
         m_row0_par_ff <= row0[0];
         m_row1_par_ff <= row1[0];
      end
   end

   // Horizontal pass on both source rows.
   always_comb begin
      h_top_in = bir_pkg::blend(bank_q_ff[{m_row0_par_ff, m_col0_par_ff}],
                                bank_q_ff[{m_row0_par_ff, m_col1_par_ff}], m_fx_ff);
      h_bot_in = bir_pkg::blend(bank_q_ff[{m_row1_par_ff, m_col0_par_ff}],
                                bank_q_ff[{m_row1_par_ff, m_col1_par_ff}], m_fx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (advance) begin
         h_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_qcol_ff <= m_qcol_ff;
         h_qrow_ff <= m_qrow_ff;
         h_fy_ff   <= m_fy_ff;
         h_top_ff  <= h_top_in;
         h_bot_ff  <= h_bot_in;
      end
   end

   // Vertical pass into the output register.
   always_comb begin
      rsp_data_in.result_pixel = bir_pkg::blend(h_top_ff, h_bot_ff, h_fy_ff);
      rsp_data_in.result_col   = h_qcol_ff;
      rsp_data_in.result_row   = h_qrow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for bilinear_image_resize_top: loads source pixels, queries
// resized pixels and compares every response with a built-in bilinear predictor.
// Depends on bir_pkg and bilinear_image_resize_top.
module tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int STORE_SIZE   = bir_pkg::MAX_SRC_WIDTH * bir_pkg::MAX_SRC_HEIGHT;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_ITEMS  = 20;
   localparam logic [bir_pkg::STEP_BITS-1:0] STEP_MAX = 24'hFF0000;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   bir_pkg::req_type              req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   bir_pkg::rsp_type              rsp_data;
   logic                          csr_we    = 1'b0;
   bir_pkg::csr_index_type        csr_index = bir_pkg::CSR_SOURCE_WIDTH;
   logic [bir_pkg::STEP_BITS-1:0] csr_wdata = '0;

   bilinear_image_resize_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: a copy of the frame store and of the four registers.
   logic [bir_pkg::PIXEL_BITS-1:0] image_copy [STORE_SIZE];
   logic [bir_pkg::SIZE_BITS-1:0]  width_reg;
   logic [bir_pkg::SIZE_BITS-1:0]  height_reg;
   logic [bir_pkg::STEP_BITS-1:0]  col_step_reg;
   logic [bir_pkg::STEP_BITS-1:0]  row_step_reg;
   bir_pkg::rsp_type               expected_pixels [$];
   int                             error_count = 0;

   // Stimulus bookkeeping: pixels already loaded and the source area in use.
   bit stocked [STORE_SIZE];
   int unsigned region_w = 1;
   int unsigned region_h = 1;
   bit feed_steady = 1'b0;
   bit sink_steady = 1'b0;
   int hold_request = 0;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_size(int unsigned value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // Truncated linear mix of two pixels by a fraction of one.
   function automatic logic [bir_pkg::PIXEL_BITS-1:0] lerp_pixel(
         logic [bir_pkg::PIXEL_BITS-1:0] a,
         logic [bir_pkg::PIXEL_BITS-1:0] b,
         logic [bir_pkg::FRAC_BITS-1:0]  f);
      logic [31:0] acc;
      acc = 32'(a) * ((32'd1 << bir_pkg::FRAC_BITS) - 32'(f)) + 32'(b) * 32'(f);
      return acc[bir_pkg::FRAC_BITS +: bir_pkg::PIXEL_BITS];
   endfunction

   // Horizontal pass over one source row; past the last column the edge pixel is used.
   function automatic logic [bir_pkg::PIXEL_BITS-1:0] row_pass(int unsigned row,
                                                               longint unsigned x,
                                                               logic [bir_pkg::FRAC_BITS-1:0] fx,
                                                               int unsigned w);
      int unsigned base;
      base = row * bir_pkg::MAX_SRC_WIDTH;
      if (x >= longint'(w - 1)) return image_copy[base + w - 1];
      return lerp_pixel(image_copy[base + int'(x)], image_copy[base + int'(x) + 1], fx);
   endfunction

   // Expected response for one query under the current registers and store.
   function automatic bir_pkg::rsp_type interp_pixel(bir_pkg::req_type r);
      int unsigned                   w;
      int unsigned                   h;
      longint unsigned               px;
      longint unsigned               py;
      longint unsigned               x;
      longint unsigned               y;
      logic [bir_pkg::FRAC_BITS-1:0] fx;
      logic [bir_pkg::FRAC_BITS-1:0] fy;
      bir_pkg::rsp_type              res;
      w  = effective_size(32'(width_reg), bir_pkg::MAX_SRC_WIDTH);
      h  = effective_size(32'(height_reg), bir_pkg::MAX_SRC_HEIGHT);
      px = 64'(r.query_col) * 64'(col_step_reg);
      py = 64'(r.query_row) * 64'(row_step_reg);
      x  = px >> bir_pkg::FRAC_BITS;
      y  = py >> bir_pkg::FRAC_BITS;
      fx = bir_pkg::FRAC_BITS'(px);
      fy = bir_pkg::FRAC_BITS'(py);
      if (y >= longint'(h - 1)) begin
         res.result_pixel = row_pass(h - 1, x, fx, w);
      end else begin
         res.result_pixel = lerp_pixel(row_pass(int'(y), x, fx, w),
                                       row_pass(int'(y) + 1, x, fx, w), fy);
      end
      res.result_col = r.query_col;
      res.result_row = r.query_row;
      return res;
   endfunction

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   // Response checking first, then the accepted request and any register write
   // update the predictor, all sampled at the rising edge.
   always @(posedge clock) begin
      bir_pkg::rsp_type want;
      if (reset) begin
         width_reg    = bir_pkg::SIZE_RESET;
         height_reg   = bir_pkg::SIZE_RESET;
         col_step_reg = bir_pkg::STEP_RESET;
         row_step_reg = bir_pkg::STEP_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected response: pixel %0d col %0d row %0d", $time,
                        rsp_data.result_pixel, rsp_data.result_col, rsp_data.result_row);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("result_pixel", 32'(want.result_pixel),
                           32'(rsp_data.result_pixel));
               check_field("result_col", 32'(want.result_col), 32'(rsp_data.result_col));
               check_field("result_row", 32'(want.result_row), 32'(rsp_data.result_row));
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.cmd == bir_pkg::CMD_LOAD) begin
               image_copy[int'(req_data.load_row) * bir_pkg::MAX_SRC_WIDTH
                          + int'(req_data.load_col)] = req_data.load_pixel;
            end else begin
               expected_pixels.push_back(interp_pixel(req_data));
            end
         end
         if (csr_we) begin
            case (csr_index)
               bir_pkg::CSR_SOURCE_WIDTH:    width_reg    = csr_wdata[bir_pkg::SIZE_BITS-1:0];
               bir_pkg::CSR_SOURCE_HEIGHT:   height_reg   = csr_wdata[bir_pkg::SIZE_BITS-1:0];
               bir_pkg::CSR_HORIZONTAL_STEP: col_step_reg = csr_wdata;
               bir_pkg::CSR_VERTICAL_STEP:   row_step_reg = csr_wdata;
            endcase
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int gap_cycles(bit steady);
      int p;
      if (steady) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready  = 1'b1;
            stall_left = gap_cycles(sink_steady);
         end
      end
   end

   // Every field random; callers then fix the ones that matter.
   function automatic bir_pkg::req_type scrambled_request();
      bir_pkg::req_type r;
      r.cmd        = bir_pkg::cmd_type'($urandom_range(0, 1));
      r.load_col   = 8'($urandom_range(0, 255));
      r.load_row   = 8'($urandom_range(0, 255));
      r.load_pixel = bir_pkg::PIXEL_BITS'($urandom_range(0, 255));
      r.query_col  = bir_pkg::COORD_BITS'($urandom_range(0, 4095));
      r.query_row  = bir_pkg::COORD_BITS'($urandom_range(0, 4095));
      return r;
   endfunction

   // Offers one request after a random gap and returns at the falling edge after
   // it is accepted, with valid still high.
   task automatic send_request(bir_pkg::req_type r);
      int gap;
      gap = gap_cycles(feed_steady);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      if (r.cmd == bir_pkg::CMD_LOAD) begin
         stocked[int'(r.load_row) * bir_pkg::MAX_SRC_WIDTH + int'(r.load_col)] = 1'b1;
      end
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic load_pixel_at(int unsigned col, int unsigned row, int unsigned value);
      bir_pkg::req_type r;
      r            = scrambled_request();
      r.cmd        = bir_pkg::CMD_LOAD;
      r.load_col   = 8'(col);
      r.load_row   = 8'(row);
      r.load_pixel = bir_pkg::PIXEL_BITS'(value);
      send_request(r);
   endtask

   task automatic query_at(int unsigned col, int unsigned row);
      bir_pkg::req_type r;
      r           = scrambled_request();
      r.cmd       = bir_pkg::CMD_QUERY;
      r.query_col = bir_pkg::COORD_BITS'(col);
      r.query_row = bir_pkg::COORD_BITS'(row);
      send_request(r);
   endtask

   // Stops offering, waits for every expected response and lets the pipeline empty.
   task automatic settle();
      req_valid = 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(bir_pkg::csr_index_type idx,
                            logic [bir_pkg::STEP_BITS-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Loads every pixel of the area in use that has not been loaded yet, so that
   // no query can touch an unwritten entry.
   task automatic fill_region();
      for (int unsigned row = 0; row < region_h; row++) begin
         for (int unsigned col = 0; col < region_w; col++) begin
            if (!stocked[row * bir_pkg::MAX_SRC_WIDTH + col]) begin
               load_pixel_at(col, row, $urandom_range(0, 255));
            end
         end
      end
   endtask

   task automatic configure(int unsigned w_val, int unsigned h_val,
                            logic [bir_pkg::STEP_BITS-1:0] col_step,
                            logic [bir_pkg::STEP_BITS-1:0] row_step);
      settle();
      write_reg(bir_pkg::CSR_SOURCE_WIDTH, bir_pkg::STEP_BITS'(w_val));
      write_reg(bir_pkg::CSR_SOURCE_HEIGHT, bir_pkg::STEP_BITS'(h_val));
      write_reg(bir_pkg::CSR_HORIZONTAL_STEP, col_step);
      write_reg(bir_pkg::CSR_VERTICAL_STEP, row_step);
      region_w = effective_size(w_val, bir_pkg::MAX_SRC_WIDTH);
      region_h = effective_size(h_val, bir_pkg::MAX_SRC_HEIGHT);
      fill_region();
   endtask

   // Values after reset: full-size source and a step of one pixel.
   task automatic test_reset_values();
      region_w = 4;
      region_h = 4;
      fill_region();
      query_at(0, 0);
      query_at(1, 2);
      query_at(2, 2);
   endtask

   // Fractional upscale, black and white extremes, and coordinates past both edges.
   task automatic test_interpolation();
      configure(5, 3, 24'h008000, 24'h00AAAA);
      load_pixel_at(0, 0, 0);
      load_pixel_at(4, 2, 255);
      load_pixel_at(1, 0, 255);
      load_pixel_at(255, 255, 255);
      query_at(0, 0);
      query_at(1, 1);
      query_at(7, 2);
      query_at(8, 3);
      query_at(4095, 4095);
      query_at(4095, 0);
      query_at(0, 4095);
   endtask

   // A zero step pins every query to the first column and row.
   task automatic test_zero_step();
      configure(5, 3, '0, '0);
      query_at(4095, 4095);
      query_at(123, 77);
   endtask

   // Size zero acts as one; sizes at and above the maximum; the largest step.
   task automatic test_size_limits();
      configure(0, 0, 24'h012345, 24'h00F00F);
      query_at(0, 0);
      query_at(4095, 4095);
      configure(256, 2, 24'h00FE00, 24'h008000);
      query_at(257, 1);
      query_at(258, 0);
      configure(511, 2, STEP_MAX, 24'h008000);
      query_at(0, 1);
      query_at(1, 2);
      configure(1, 256, 24'h008000, 24'h00FE00);
      query_at(1, 257);
      query_at(2, 258);
      configure(1, 511, 24'h008000, STEP_MAX);
      query_at(1, 1);
   endtask

   // The receiver holds off while queries keep coming, so the pipeline fills and
   // stalls its input; afterwards the sender waits until every response is back.
   task automatic test_backpressure();
      configure(6, 6, 24'h008000, 24'h00B6DB);
      feed_steady  = 1'b1;
      hold_request = 150;
      repeat (40) query_at($urandom_range(0, 11), $urandom_range(0, 7));
      feed_steady = 1'b0;
      settle();
   endtask

   function automatic int unsigned pick_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return 0;
      if (p < 80) return $urandom_range(1, 12);
      return $urandom_range(13, 24);
   endfunction

   // Mostly the (src-1)/(dst-1) step that software programs, sometimes extremes.
   function automatic logic [bir_pkg::STEP_BITS-1:0] pick_step(int unsigned src,
                                                              int unsigned dst);
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) begin
         return (dst <= 1) ? '0
                : bir_pkg::STEP_BITS'(((src - 1) << bir_pkg::FRAC_BITS) / (dst - 1));
      end
      if (p < 75) return '0;
      if (p < 82) return STEP_MAX;
      return bir_pkg::STEP_BITS'($urandom_range(0, STEP_MAX));
   endfunction

   // Random sizes and steps per phase; loads and queries mixed within a phase.
   task automatic test_random_resize();
      int unsigned      w_val;
      int unsigned      h_val;
      int unsigned      dst_w;
      int unsigned      dst_h;
      bir_pkg::req_type r;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         w_val = pick_size();
         h_val = pick_size();
         dst_w = $urandom_range(1, 2 * effective_size(w_val, bir_pkg::MAX_SRC_WIDTH) + 4);
         dst_h = $urandom_range(1, 2 * effective_size(h_val, bir_pkg::MAX_SRC_HEIGHT) + 4);
         configure(w_val, h_val,
                   pick_step(effective_size(w_val, bir_pkg::MAX_SRC_WIDTH), dst_w),
                   pick_step(effective_size(h_val, bir_pkg::MAX_SRC_HEIGHT), dst_h));
         feed_steady = ($urandom_range(0, 3) == 0);
         sink_steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = scrambled_request();
            if ($urandom_range(0, 99) < 25) begin
               r.cmd = bir_pkg::CMD_LOAD;
               if ($urandom_range(0, 99) < 70) begin
                  r.load_col = 8'($urandom_range(0, region_w - 1));
                  r.load_row = 8'($urandom_range(0, region_h - 1));
               end
            end else begin
               r.cmd = bir_pkg::CMD_QUERY;
               if ($urandom_range(0, 99) < 80) begin
                  r.query_col = bir_pkg::COORD_BITS'($urandom_range(0, dst_w));
                  r.query_row = bir_pkg::COORD_BITS'($urandom_range(0, dst_h));
               end
            end
            send_request(r);
         end
      end
      feed_steady = 1'b0;
      sink_steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_interpolation();
      test_zero_step();
      test_size_limits();
      test_backpressure();
      test_random_resize();
      settle();
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

FILE: bilinear_image_resize_top.f
hdl/bir_pkg.sv
hdl/bilinear_image_resize_top.sv
tb/tb.sv
